// File: hdl/pls_pkg.sv
// Shared types, constants and helpers for the point light diffuse shader.
package pls_pkg;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_POS_X    = 3'd0,
		REG_POS_Y    = 3'd1,
		REG_POS_Z    = 3'd2,
		REG_RED      = 3'd3,
		REG_GREEN    = 3'd4,
		REG_BLUE     = 3'd5,
		REG_STRENGTH = 3'd6,
		REG_REACH    = 3'd7
	} reg_idx_t;

	// Ambient term 0.005 in Q.16, epsilon 1e-6 in Q32.32, one in Q1.16
	localparam logic [37:0] AMBIENT = 38'd328;
	localparam logic [63:0] EPS     = 64'd4295;
	localparam logic [16:0] ONE     = 17'd65536;

	// Stage counts of the iterative units
	localparam int ROOT_STEPS = 32;
	localparam int NDL_STEPS  = 20;

	// Per-item data that rides alongside the root and divide unit
	typedef struct packed {
		logic        hi;
		logic        sat;
		logic        beyond;
		logic [50:0] n2;
		logic [16:0] mat_r;
		logic [16:0] mat_g;
		logic [16:0] mat_b;
		logic [16:0] alpha;
	} side_t;

	// Per-item data that rides alongside the Lambert divider
	typedef struct packed {
		logic        beyond;
		logic [31:0] atten;
		logic [16:0] mat_r;
		logic [16:0] mat_g;
		logic [16:0] mat_b;
		logic [16:0] alpha;
	} back_t;

	// Magnitude of a 33-bit signed difference; it always fits 32 bits
	function automatic logic [31:0] mag33(input logic signed [32:0] v);
		logic [32:0] m;
		m = v[32] ? 33'(-v) : 33'(v);
		return m[31:0];
	endfunction

endpackage

// File: hdl/pls_root_div.sv
// Pipelined integer square root and 64-bit divider, one result bit per stage.
module pls_root_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 valid_in,
	input  logic [63:0]          dk,
	input  logic [63:0]          num,
	input  logic [63:0]          dv,
	input  pls_pkg::side_t       side_in,
	output logic                 valid_out,
	output logic [31:0]          root,
	output logic [31:0]          quo,
	output pls_pkg::side_t       side_out
);

	logic                 v_s    [0:pls_pkg::ROOT_STEPS];
	logic [63:0]          dk_s   [0:pls_pkg::ROOT_STEPS];
	logic [33:0]          srem_s [0:pls_pkg::ROOT_STEPS];
	logic [31:0]          root_s [0:pls_pkg::ROOT_STEPS];
	logic [63:0]          num_s  [0:pls_pkg::ROOT_STEPS];
	logic [63:0]          dv_s   [0:pls_pkg::ROOT_STEPS];
	logic [63:0]          drem_s [0:pls_pkg::ROOT_STEPS];
	logic [31:0]          quo_s  [0:pls_pkg::ROOT_STEPS];
	pls_pkg::side_t       side_s [0:pls_pkg::ROOT_STEPS];

	// Load the head of the chain
	assign v_s[0]    = valid_in;
	assign dk_s[0]   = dk;
	assign srem_s[0] = '0;
	assign root_s[0] = '0;
	assign num_s[0]  = num;
	assign dv_s[0]   = dv;
	assign drem_s[0] = {32'd0, num[63:32]};
	assign quo_s[0]  = '0;
	assign side_s[0] = side_in;

	for (genvar k = 0; k < pls_pkg::ROOT_STEPS; k++) begin : g_step
		logic [35:0] trial;
		logic [35:0] tst;
		logic [33:0] srem_n;
		logic [31:0] root_n;
		logic [64:0] dtrial;
		logic [63:0] drem_n;
		logic        qbit;

		// Square root: bring down two bits, try the next root bit
		always_comb begin
			trial = {srem_s[k], dk_s[k][63-2*k -: 2]};
			tst   = {2'b00, root_s[k], 2'b01};
			if (trial >= tst) begin
				srem_n = 34'(trial - tst);
				root_n = {root_s[k][30:0], 1'b1};
			end else begin
				srem_n = trial[33:0];
				root_n = {root_s[k][30:0], 1'b0};
			end
		end

		// Division: bring down one bit, subtract the divisor when it fits
		always_comb begin
			dtrial = {drem_s[k], num_s[k][31-k]};
			qbit   = (dtrial >= {1'b0, dv_s[k]});
			if (qbit) begin
				drem_n = 64'(dtrial - {1'b0, dv_s[k]});
			end else begin
				drem_n = dtrial[63:0];
			end
		end

		// Advance valid bits
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (adv) begin
				v_s[k+1] <= v_s[k];
			end
		end

		// Advance payload
		always_ff @(posedge clk) begin
			if (adv) begin
				dk_s[k+1]   <= dk_s[k];
				srem_s[k+1] <= srem_n;
				root_s[k+1] <= root_n;
				num_s[k+1]  <= num_s[k];
				dv_s[k+1]   <= dv_s[k];
				drem_s[k+1] <= drem_n;
				quo_s[k+1]  <= {quo_s[k][30:0], qbit};
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign valid_out = v_s[pls_pkg::ROOT_STEPS];
	assign root      = root_s[pls_pkg::ROOT_STEPS];
	assign quo       = quo_s[pls_pkg::ROOT_STEPS];
	assign side_out  = side_s[pls_pkg::ROOT_STEPS];

endmodule

// File: hdl/point_light_diffuse_shader_top.sv
// Top level of the point light diffuse shader pipeline.
//
//  channel | signals                              | direction
//  --------+--------------------------------------+-----------
//  in      | in_valid, in_stall, point/normal/mat | beat in
//  out     | out_valid, out_stall, shade_*        | beat out
//  cfg     | cfg_we, cfg_index, cfg_data          | write only
//
// One beat per cycle enters unless the output stalls. The pipe has four
// front stages, a 32-stage root and attenuation divider, a 20-stage
// Lambert divider and four stages of color products. Reset clears every
// valid bit and the light registers. A stalled output freezes the whole
// pipe, and the input stalls with it even when earlier stages are empty.
module point_light_diffuse_shader_top (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic signed [15:0] normal_z,
	input  logic [16:0]        material_red,
	input  logic [16:0]        material_green,
	input  logic [16:0]        material_blue,
	input  logic [16:0]        material_alpha,
	// output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [16:0]        shade_red,
	output logic [16:0]        shade_green,
	output logic [16:0]        shade_blue,
	output logic [16:0]        shade_alpha
);

	// Light registers
	logic [31:0] pos_x_q, pos_y_q, pos_z_q;
	logic [16:0] col_q [0:2];
	logic [31:0] strength_q, reach_q;
	logic [63:0] r2_q;

	logic adv;

	// Write light registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q    <= '0;
			pos_y_q    <= '0;
			pos_z_q    <= '0;
			col_q[0]   <= '0;
			col_q[1]   <= '0;
			col_q[2]   <= '0;
			strength_q <= '0;
			reach_q    <= '0;
		end else if (cfg_we) begin
			unique case (pls_pkg::reg_idx_t'(cfg_index))
				pls_pkg::REG_POS_X:    pos_x_q    <= cfg_data;
				pls_pkg::REG_POS_Y:    pos_y_q    <= cfg_data;
				pls_pkg::REG_POS_Z:    pos_z_q    <= cfg_data;
				pls_pkg::REG_RED:      col_q[0]   <= cfg_data[16:0];
				pls_pkg::REG_GREEN:    col_q[1]   <= cfg_data[16:0];
				pls_pkg::REG_BLUE:     col_q[2]   <= cfg_data[16:0];
				pls_pkg::REG_STRENGTH: strength_q <= cfg_data;
				pls_pkg::REG_REACH:    reach_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Square the reach into a register shared by all beats; it follows the register in the next cycle
	always_ff @(posedge clk) begin
		r2_q <= {32'd0, reach_q} * {32'd0, reach_q};
	end

	// Advance whenever the output register is empty or being taken
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// ---------------- Stage 1: vector to the light
	logic               v_s1;
	logic signed [32:0] d_s1 [0:2];
	logic signed [15:0] n_s1 [0:2];
	logic [16:0]        mat_s1 [0:2];
	logic [16:0]        alpha_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1[0]   <= $signed({pos_x_q[31], pos_x_q}) - $signed({point_x[31], point_x});
			d_s1[1]   <= $signed({pos_y_q[31], pos_y_q}) - $signed({point_y[31], point_y});
			d_s1[2]   <= $signed({pos_z_q[31], pos_z_q}) - $signed({point_z[31], point_z});
			n_s1[0]   <= normal_x;
			n_s1[1]   <= normal_y;
			n_s1[2]   <= normal_z;
			mat_s1[0] <= material_red;
			mat_s1[1] <= material_green;
			mat_s1[2] <= material_blue;
			alpha_s1  <= material_alpha;
		end
	end

	// ---------------- Stage 2: squares and normal products
	logic               v_s2;
	logic [63:0]        sq_s2 [0:2];
	logic signed [47:0] pn_s2 [0:2];
	logic [16:0]        mat_s2 [0:2];
	logic [16:0]        alpha_s2;
	logic [31:0]        m_c [0:2];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			m_c[i] = pls_pkg::mag33(d_s1[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sq_s2[i]  <= {32'd0, m_c[i]} * {32'd0, m_c[i]};
				pn_s2[i]  <= 48'(n_s1[i]) * 48'(d_s1[i]);
				mat_s2[i] <= mat_s1[i];
			end
			alpha_s2 <= alpha_s1;
		end
	end

	// ---------------- Stage 3: squared distance and dot product
	logic               v_s3;
	logic [65:0]        dsq_s3;
	logic signed [49:0] dot_s3;
	logic [16:0]        mat_s3 [0:2];
	logic [16:0]        alpha_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dsq_s3 <= {2'b00, sq_s2[0]} + {2'b00, sq_s2[1]} + {2'b00, sq_s2[2]};
			dot_s3 <= 50'(pn_s2[0]) + 50'(pn_s2[1]) + 50'(pn_s2[2]);
			for (int i = 0; i < 3; i++) begin
				mat_s3[i] <= mat_s2[i];
			end
			alpha_s3 <= alpha_s2;
		end
	end

	// ---------------- Stage 4: range test and divider operands
	logic           v_s4;
	logic [63:0]    dk_s4, num_s4, dv_s4;
	pls_pkg::side_t side_s4;
	logic           hi_c;
	logic [63:0]    dk_c, dv_c, num_c;

	always_comb begin
		hi_c  = (dsq_s3[65:64] != 2'b00);
		dk_c  = hi_c ? dsq_s3[65:2] : dsq_s3[63:0];
		dv_c  = (!hi_c && dk_c < pls_pkg::EPS) ? pls_pkg::EPS : dk_c;
		num_c = hi_c ? {2'b00, strength_q, 30'd0} : {strength_q, 32'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dk_s4          <= dk_c;
			num_s4         <= num_c;
			dv_s4          <= dv_c;
			side_s4.hi     <= hi_c;
			side_s4.sat    <= ({32'd0, num_c[63:32]} >= dv_c);
			side_s4.beyond <= (reach_q != 32'd0) && (dsq_s3 > {2'b00, r2_q});
			side_s4.n2     <= (dot_s3 > 50'sd0) ? {dot_s3[48:0], 2'b00} : 51'd0;
			side_s4.mat_r  <= mat_s3[0];
			side_s4.mat_g  <= mat_s3[1];
			side_s4.mat_b  <= mat_s3[2];
			side_s4.alpha  <= alpha_s3;
		end
	end

	// ---------------- Distance root and attenuation quotient
	logic           v_rd;
	logic [31:0]    root_rd, quo_rd;
	pls_pkg::side_t side_rd;

	pls_root_div u_root_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.valid_in  (v_s4),
		.dk        (dk_s4),
		.num       (num_s4),
		.dv        (dv_s4),
		.side_in   (side_s4),
		.valid_out (v_rd),
		.root      (root_rd),
		.quo       (quo_rd),
		.side_out  (side_rd)
	);

	// ---------------- Lambert divider: ndotl = 4 max(n . L, 0) / |L|
	logic           nd_v_s    [0:pls_pkg::NDL_STEPS];
	logic [50:0]    nd_num_s  [0:pls_pkg::NDL_STEPS];
	logic [32:0]    nd_dv_s   [0:pls_pkg::NDL_STEPS];
	logic [32:0]    nd_rem_s  [0:pls_pkg::NDL_STEPS];
	logic [19:0]    nd_q_s    [0:pls_pkg::NDL_STEPS];
	pls_pkg::back_t nd_side_s [0:pls_pkg::NDL_STEPS];
	logic [32:0]    dist_c;

	// Rescale the root and pick the saturated attenuation
	always_comb begin
		dist_c                = side_rd.hi ? {root_rd, 1'b0} : {1'b0, root_rd};
		nd_v_s[0]             = v_rd;
		nd_num_s[0]           = side_rd.n2;
		nd_dv_s[0]            = (dist_c == 33'd0) ? 33'd1 : dist_c;
		nd_rem_s[0]           = {2'b00, side_rd.n2[50:20]};
		nd_q_s[0]             = '0;
		nd_side_s[0].beyond   = side_rd.beyond;
		nd_side_s[0].atten    = side_rd.sat ? 32'hFFFF_FFFF : quo_rd;
		nd_side_s[0].mat_r    = side_rd.mat_r;
		nd_side_s[0].mat_g    = side_rd.mat_g;
		nd_side_s[0].mat_b    = side_rd.mat_b;
		nd_side_s[0].alpha    = side_rd.alpha;
	end

	for (genvar k = 0; k < pls_pkg::NDL_STEPS; k++) begin : g_ndl
		logic [33:0] trial;
		logic        qbit;
		logic [32:0] rem_n;

		// Bring down one bit, subtract the distance when it fits
		always_comb begin
			trial = {nd_rem_s[k], nd_num_s[k][19-k]};
			qbit  = (trial >= {1'b0, nd_dv_s[k]});
			if (qbit) begin
				rem_n = 33'(trial - {1'b0, nd_dv_s[k]});
			end else begin
				rem_n = trial[32:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				nd_v_s[k+1] <= 1'b0;
			end else if (adv) begin
				nd_v_s[k+1] <= nd_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				nd_num_s[k+1]  <= nd_num_s[k];
				nd_dv_s[k+1]   <= nd_dv_s[k];
				nd_rem_s[k+1]  <= rem_n;
				nd_q_s[k+1]    <= {nd_q_s[k][18:0], qbit};
				nd_side_s[k+1] <= nd_side_s[k];
			end
		end
	end

	logic           v_nd;
	logic [19:0]    ndotl;
	pls_pkg::back_t bk;

	assign v_nd  = nd_v_s[pls_pkg::NDL_STEPS];
	assign ndotl = nd_q_s[pls_pkg::NDL_STEPS];
	assign bk    = nd_side_s[pls_pkg::NDL_STEPS];

	// ---------------- Stage 5: color times ndotl, material times alpha
	logic        v_s5;
	logic [20:0] t_s5 [0:2];
	logic [33:0] ma_s5 [0:2];
	logic        beyond_s5;
	logic [31:0] atten_s5;
	logic [16:0] alpha_s5;
	logic [16:0] mat_c [0:2];
	logic [36:0] tp_c [0:2];

	always_comb begin
		mat_c[0] = bk.mat_r;
		mat_c[1] = bk.mat_g;
		mat_c[2] = bk.mat_b;
		for (int i = 0; i < 3; i++) begin
			tp_c[i] = {20'd0, col_q[i]} * {17'd0, ndotl};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_nd;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				t_s5[i]  <= tp_c[i][36:16];
				ma_s5[i] <= {17'd0, mat_c[i]} * {17'd0, bk.alpha};
			end
			beyond_s5 <= bk.beyond;
			atten_s5  <= bk.atten;
			alpha_s5  <= bk.alpha;
		end
	end

	// ---------------- Stage 6: diffuse term plus ambient
	logic        v_s6;
	logic [37:0] s_s6 [0:2];
	logic [33:0] ma_s6 [0:2];
	logic [16:0] alpha_s6;
	logic [52:0] dp_c [0:2];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dp_c[i] = {32'd0, t_s5[i]} * {21'd0, atten_s5};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				// drop the diffuse term outside the reach
				s_s6[i]  <= beyond_s5 ? pls_pkg::AMBIENT
					: ({1'b0, dp_c[i][52:16]} + pls_pkg::AMBIENT);
				ma_s6[i] <= ma_s5[i];
			end
			alpha_s6 <= alpha_s5;
		end
	end

	// ---------------- Stage 7: scale by material and alpha, split product
	logic        v_s7;
	logic [65:0] plo_s7 [0:2];
	logic [39:0] phi_s7 [0:2];
	logic [16:0] alpha_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				plo_s7[i] <= {32'd0, ma_s6[i]} * {34'd0, s_s6[i][31:0]};
				phi_s7[i] <= {6'd0, ma_s6[i]} * {34'd0, s_s6[i][37:32]};
			end
			alpha_s7 <= alpha_s6;
		end
	end

	// ---------------- Stage 8: round, clamp, output register
	logic        v_s8;
	logic [16:0] shade_s8 [0:2];
	logic [16:0] alpha_s8;
	logic [66:0] rnd_c [0:2];
	logic [40:0] r_c [0:2];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rnd_c[i] = {1'b0, plo_s7[i]} + 67'h8000_0000;
			r_c[i]   = {6'd0, rnd_c[i][66:32]} + {1'b0, phi_s7[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				shade_s8[i] <= (r_c[i] > {24'd0, pls_pkg::ONE}) ? pls_pkg::ONE : r_c[i][16:0];
			end
			alpha_s8 <= alpha_s7;
		end
	end

	assign out_valid   = v_s8;
	assign shade_red   = shade_s8[0];
	assign shade_green = shade_s8[1];
	assign shade_blue  = shade_s8[2];
	assign shade_alpha = alpha_s8;

endmodule

// File: test/point_light_diffuse_shader_top_tb.sv
// Self-checking testbench for the point light diffuse shader top level.
module point_light_diffuse_shader_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [31:0] px, py, pz;
		logic signed [15:0] nx, ny, nz;
		logic [16:0]        mr, mg, mb, ma;
	} surf_t;

	typedef struct packed {
		logic [16:0] r, g, b, a;
	} shade_t;

	typedef logic [7:0][31:0] light_t;

	typedef struct {
		int     lt;
		surf_t  s;
		bit     typed;
		shade_t e;
	} row_t;

	localparam int WATCH_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 80;
	localparam logic [16:0] ONE = pls_pkg::ONE;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	surf_t cur = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	shade_t got;

	// light registers as the block should hold them
	logic [31:0] lreg [8];
	shade_t shade_q [$];
	light_t lights [4];
	row_t rows [$];

	int errors = 0;
	int shaded = 0;
	int sent = 0;
	int settings = 0;
	int burst_left = 0;
	int hold_asks = 0;
	int hold_seen = 0;
	int hold_cnt = 0;
	int stall_mode = 0;
	int stall_tick = 0;
	int idle_cycles = 0;

	always #1 clk = ~clk;

	point_light_diffuse_shader_top DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.point_x(cur.px), .point_y(cur.py), .point_z(cur.pz),
		.normal_x(cur.nx), .normal_y(cur.ny), .normal_z(cur.nz),
		.material_red(cur.mr), .material_green(cur.mg),
		.material_blue(cur.mb), .material_alpha(cur.ma),
		.out_valid(out_valid), .out_stall(out_stall),
		.shade_red(got.r), .shade_green(got.g),
		.shade_blue(got.b), .shade_alpha(got.a)
	);

	// integer square root, bit by bit
	function automatic bit [63:0] root64(input bit [63:0] v);
		bit [63:0] rem, res, b;
		rem = v;
		res = 0;
		b = 64'd1 << 62;
		while (b > rem) b >>= 2;
		while (b != 0) begin
			if (rem >= res + b) begin
				rem -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// material * alpha * s, rounded half up, clamped to one
	function automatic logic [16:0] blend(input bit [63:0] mat, alpha, s);
		bit [63:0] ma, r;
		ma = mat * alpha;
		if (ma != 0 && s > (64'hFFFF_FFFF_FFFF_FFFF - 64'h8000_0000) / ma) return ONE;
		r = (ma * s + 64'h8000_0000) >> 32;
		return (r > 64'd65536) ? ONE : r[16:0];
	endfunction

	// lit color of one surface point under the current light
	function automatic shade_t shade_point(input surf_t s);
		longint d [3];
		longint dot;
		bit [63:0] m, sq, lo, hi, dk, dlen, ndl, atten, t, dif, col [3], mat [3];
		logic signed [31:0] lp [3];
		logic signed [15:0] n [3];
		logic signed [31:0] p [3];
		shade_t o;
		lp = '{lreg[pls_pkg::REG_POS_X], lreg[pls_pkg::REG_POS_Y], lreg[pls_pkg::REG_POS_Z]};
		p = '{s.px, s.py, s.pz};
		n = '{s.nx, s.ny, s.nz};
		col = '{64'(lreg[pls_pkg::REG_RED]), 64'(lreg[pls_pkg::REG_GREEN]),
			64'(lreg[pls_pkg::REG_BLUE])};
		mat = '{64'(s.mr), 64'(s.mg), 64'(s.mb)};
		lo = 0;
		hi = 0;
		dot = 0;
		ndl = 0;
		for (int i = 0; i < 3; i++) begin
			d[i] = longint'(lp[i]) - longint'(p[i]);
			m = (d[i] < 0) ? 64'(-d[i]) : 64'(d[i]);
			sq = m * m;
			lo += sq;
			if (lo < sq) hi++;
			dot += longint'(n[i]) * d[i];
		end
		o.a = s.ma;
		// beyond reach leaves only the ambient term
		if (lreg[pls_pkg::REG_REACH] != 0 &&
				(hi != 0 || lo > 64'(lreg[pls_pkg::REG_REACH]) *
				64'(lreg[pls_pkg::REG_REACH]))) begin
			o.r = blend(mat[0], s.ma, 64'(pls_pkg::AMBIENT));
			o.g = blend(mat[1], s.ma, 64'(pls_pkg::AMBIENT));
			o.b = blend(mat[2], s.ma, 64'(pls_pkg::AMBIENT));
			return o;
		end
		if (hi == 0) begin
			dk = lo;
			dlen = root64(dk);
			atten = (64'(lreg[pls_pkg::REG_STRENGTH]) << 32) /
				((dk > pls_pkg::EPS) ? dk : pls_pkg::EPS);
		end else begin
			dk = (hi << 62) | (lo >> 2);
			dlen = root64(dk) << 1;
			atten = (64'(lreg[pls_pkg::REG_STRENGTH]) << 30) / dk;
		end
		if (atten > 64'hFFFF_FFFF) atten = 64'hFFFF_FFFF;
		if (dot > 0 && dlen != 0) ndl = (64'(dot) << 2) / dlen;
		for (int i = 0; i < 3; i++) begin
			t = (col[i] * ndl) >> 16;
			dif = (t * atten) >> 16;
			mat[i] = blend(mat[i], s.ma, dif + 64'(pls_pkg::AMBIENT));
		end
		o.r = mat[0][16:0];
		o.g = mat[1][16:0];
		o.b = mat[2][16:0];
		return o;
	endfunction

	function automatic light_t mk_light(input logic [31:0] x, y, z, r, g, b, st, rc);
		light_t l;
		l[pls_pkg::REG_POS_X] = x;
		l[pls_pkg::REG_POS_Y] = y;
		l[pls_pkg::REG_POS_Z] = z;
		l[pls_pkg::REG_RED] = r;
		l[pls_pkg::REG_GREEN] = g;
		l[pls_pkg::REG_BLUE] = b;
		l[pls_pkg::REG_STRENGTH] = st;
		l[pls_pkg::REG_REACH] = rc;
		return l;
	endfunction

	function automatic logic [31:0] near(input logic [31:0] c, input int span);
		return c + 32'($urandom_range(0, 2 * span)) - 32'(span);
	endfunction

	function automatic logic [16:0] rand_mat();
		return ($urandom_range(0, 7) == 0) ? ONE : 17'($urandom_range(0, 65536));
	endfunction

	// drain the pipe, then load all eight light registers
	task automatic load_light(input light_t l);
		while (shade_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= l[i];
			lreg[i] = (i >= pls_pkg::REG_RED && i <= pls_pkg::REG_BLUE) ?
				(l[i] & 32'h1FFFF) : l[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		settings++;
	endtask

	// offer one beat, hold it until taken, then maybe pause
	task automatic send_point(input surf_t s, input bit typed, input shade_t e);
		int gap;
		cur <= s;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		shade_q.push_back(typed ? e : shade_point(s));
		sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 40);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// random point: mostly close to the light, sometimes anywhere
	function automatic surf_t rand_point(input int span);
		surf_t s;
		if ($urandom_range(0, 4) == 0) begin
			s.px = $urandom;
			s.py = $urandom;
			s.pz = $urandom;
		end else begin
			s.px = near(lreg[pls_pkg::REG_POS_X], span);
			s.py = near(lreg[pls_pkg::REG_POS_Y], span);
			s.pz = near(lreg[pls_pkg::REG_POS_Z], span);
		end
		s.nx = 16'($urandom);
		s.ny = 16'($urandom);
		s.nz = 16'($urandom);
		if ($urandom_range(0, 1) == 0) begin
			s.nx = s.nx >>> 2;
			s.ny = s.ny >>> 2;
			s.nz = s.nz >>> 2;
		end
		s.mr = rand_mat();
		s.mg = rand_mat();
		s.mb = rand_mat();
		s.ma = rand_mat();
		return s;
	endfunction

	// receiver: long hold on request, otherwise a shifting stall pattern
	always @(posedge clk) begin
		stall_tick <= stall_tick + 1;
		if (stall_tick % 64 == 0) stall_mode <= $urandom_range(0, 3);
		if (hold_cnt > 0) begin
			out_stall <= 1'b1;
			hold_cnt <= hold_cnt - 1;
		end else if (hold_seen != hold_asks) begin
			hold_seen <= hold_asks;
			hold_cnt <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 9) < 3);
				2: out_stall <= ($urandom_range(0, 9) < 7);
				default: out_stall <= stall_tick[1];
			endcase
		end
	end

	// compare each result beat with the oldest expectation; watch for a hang
	always @(posedge clk) begin
		shade_t e;
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("timeout: no beat for %0d cycles, %0d results pending",
				WATCH_LIMIT, shade_q.size());
			$display("RESULT: ERROR");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			shaded++;
			if (shade_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result beat %p", got);
			end else begin
				e = shade_q.pop_front();
				if (got !== e) begin
					errors++;
					if (errors <= 10)
						$display("mismatch at result %0d: exp r%0d g%0d b%0d a%0d got r%0d g%0d b%0d a%0d",
							shaded, e.r, e.g, e.b, e.a, got.r, got.g, got.b, got.a);
				end
			end
		end
	end

	initial begin
		int lt;
		for (int i = 0; i < 8; i++) lreg[i] = '0;
		lights[0] = '0;
		lights[1] = mk_light(0, 0, 0, 65536, 65536, 65536, 65536, 10 << 16);
		lights[2] = mk_light(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h1FFFF, 65536, 0, 32'hFFFF_FFFF, 0);
		lights[3] = mk_light(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			30000, 65536, 1, 0, 32'hFFFF_FFFF);

		// reset light: only ambient can show
		rows.push_back('{0, '{0, 0, 0, 0, 0, 0, ONE, ONE, ONE, ONE}, 1, '{328, 328, 328, ONE}});
		rows.push_back('{0, '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF, 16'h7FFF,
			16'h7FFF, 0, 0, 0, ONE}, 1, '{0, 0, 0, ONE}});
		rows.push_back('{0, '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h8000,
			16'h8000, ONE, ONE, ONE, 0}, 1, '{0, 0, 0, 0}});
		rows.push_back('{0, '{5 << 16, 0, 0, 16384, 0, 0, 32768, 32768, 32768, 32768}, 1,
			'{82, 82, 82, 32768}});
		// white light at origin with reach of ten
		rows.push_back('{1, '{0, 0, 0, 16384, 0, 0, ONE, ONE, ONE, ONE}, 0, '0});
		rows.push_back('{1, '{65536, 0, 0, -16384, 0, 0, ONE, 40000, 100, ONE}, 0, '0});
		rows.push_back('{1, '{65536, 0, 0, 16384, 0, 0, ONE, ONE, ONE, ONE}, 0, '0});
		rows.push_back('{1, '{20 << 16, 0, 0, -16384, 0, 0, ONE, ONE, ONE, ONE}, 0, '0});
		rows.push_back('{1, '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, -16384, 0, 0,
			ONE, ONE, ONE, ONE}, 0, '0});
		rows.push_back('{1, '{0, 32768, 0, 0, -16384, 0, ONE, 20000, ONE, 50000}, 0, '0});
		// far corner light, color above one, strongest falloff numerator
		rows.push_back('{2, '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h7FFF, 16'h7FFF,
			16'h7FFF, ONE, ONE, ONE, ONE}, 0, '0});
		rows.push_back('{2, '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16384, 0, 0,
			ONE, ONE, ONE, ONE}, 0, '0});
		rows.push_back('{2, '{32'h7FFF_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, -16384, 0, 0,
			ONE, ONE, ONE, ONE}, 0, '0});
		// opposite corner, zero strength, widest reach
		rows.push_back('{3, '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h8000, 0, 0,
			ONE, ONE, ONE, ONE}, 0, '0});
		rows.push_back('{3, '{32'h8001_0000, 32'h8000_0000, 32'h8000_0000, 16'h8000, 0, 0,
			ONE, 123, ONE, 65535}, 0, '0});

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		lt = 0;
		foreach (rows[i]) begin
			if (rows[i].lt != lt) begin
				lt = rows[i].lt;
				in_valid <= 1'b0;
				load_light(lights[lt]);
			end
			send_point(rows[i].s, rows[i].typed, rows[i].e);
		end

		// random phases under random and extreme lights
		for (int ph = 0; ph < 7; ph++) begin
			light_t l;
			int span;
			l = mk_light(near(0, 100 << 16), near(0, 100 << 16), near(0, 100 << 16),
				$urandom_range(0, 65536), $urandom_range(0, 65536), $urandom_range(0, 65536),
				$urandom_range(0, 32'h0040_0000), 0);
			if (ph % 2 == 1) l[pls_pkg::REG_REACH] = $urandom_range(1 << 16, 12 << 16);
			if (ph == 5) l = lights[2];
			if (ph == 6) begin
				l[pls_pkg::REG_STRENGTH] = $urandom;
				l[pls_pkg::REG_RED] = 32'h1FFFF;
				l[pls_pkg::REG_POS_X] = $urandom;
			end
			in_valid <= 1'b0;
			load_light(l);
			if (ph == 1) hold_asks++;
			span = (ph == 4) ? 32'h0100_0000 : (8 << 16);
			repeat (270) send_point(rand_point(span), 0, '0);
		end
		in_valid <= 1'b0;

		while (shade_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d points over %0d light settings, %0d results checked",
			sent, settings, shaded);
		$display("ambient-only, beyond-reach, zero-distance and saturation paths driven");
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches", errors);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// File: filelist.f
hdl/pls_pkg.sv
hdl/pls_root_div.sv
hdl/point_light_diffuse_shader_top.sv
test/point_light_diffuse_shader_top_tb.sv
